// ----- rtl/spcs_pkg.sv -----
// Shared types, constants and table helpers of the sine PWM commutation sequencer.
package spcs_pkg;

    // Default sizes handed to the top level parameters.
    localparam int unsigned COS_TABLE_BITS_DEF = 10;
    localparam int unsigned ENCODER_COUNTS_DEF = 2048;

    // Angle constants, a full turn is 2^32.
    localparam logic [31:0] HALF_PI_Q30    = 32'd1686629713;
    localparam logic [31:0] THIRD_TURN     = 32'h5555_5555;
    localparam logic [31:0] TWO_THIRD_TURN = 32'hAAAA_AAAB;
    localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;
    localparam logic [15:0] COS_OFFSET     = 16'h8000;

    // Configuration register reset values that do not depend on parameters.
    localparam logic [15:0] STEPS_RESET     = 16'd1000;
    localparam logic [6:0]  POLE_RESET      = 7'd4;
    localparam logic [31:0] PHASE_STEP_RESET = 32'd4294967;
    localparam logic [15:0] DUTY_RESET      = 16'd0;
    localparam logic [15:0] RELOAD_RESET    = 16'hFFFF;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_STEPS_PER_TURN  = 3'd0,
        REG_POLE_RATIO      = 3'd1,
        REG_PHASE_STEP      = 3'd2,
        REG_COUNTS_PER_TURN = 3'd3,
        REG_COUNT_TO_PHASE  = 3'd4,
        REG_DUTY_MAX        = 3'd5,
        REG_RELOAD_VALUE    = 3'd6,
        REG_INVERT_MODE     = 3'd7
    } cfg_index_t;

    // Stage codes.
    localparam logic [1:0] STG_ALIGN  = 2'd0;
    localparam logic [1:0] STG_OPEN   = 2'd1;
    localparam logic [1:0] STG_CLOSED = 2'd2;

    // Phase selector for the shared compare value unit.
    typedef enum logic [1:0] {
        PH_U = 2'd0,
        PH_V = 2'd1,
        PH_W = 2'd2
    } phase_t;

    // Request payloads.
    typedef struct packed {
        logic               command;
        logic signed [31:0] encoder_position;
    } in_t;

    typedef struct packed {
        logic [15:0] duty_u;
        logic [15:0] duty_v;
        logic [15:0] duty_w;
        logic [1:0]  stage;
        logic        encoder_reset;
        logic [31:0] electrical_angle;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   capture;
        logic   clear;
        logic   advance;
        logic   div_load;
        logic   div_step;
        logic   enc_fix;
        logic   enc_mul;
        logic   rom_read;
        logic   mul;
        logic   store;
        logic   load_out;
        phase_t phase;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_cmd;
        logic closed;
        logic div_last;
        logic out_free;
    } stat_t;

    // Angle offset of each phase.
    function automatic logic [31:0] phase_offset(phase_t p);
        logic [31:0] r;
        case (p)
            PH_U:    r = 32'd0;
            PH_V:    r = THIRD_TURN;
            PH_W:    r = TWO_THIRD_TURN;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Quotient by compare and subtract, one bit per step.
    // Only evaluated at elaboration while the table is built.
    function automatic logic [63:0] series_quot(logic [63:0] n, logic [8:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= 64'(d)) begin
                r    = r - 64'(d);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // One quarter-wave cosine entry in Q1.15, from a Q30 Taylor series.
    // Only evaluated at elaboration to build the table.
    function automatic logic [15:0] cos_entry(int unsigned i, int unsigned tab_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [8:0]         dv;
        logic signed [63:0] sum;
        logic [63:0]        q;
        logic [15:0]        r;
        x    = (64'(i) * 64'(HALF_PI_Q30)) >> tab_bits;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = 64'sd1 <<< 30;
        for (int unsigned k = 1; k <= 9; k++) begin
            dv   = 9'((2 * k - 1) * (2 * k));
            term = series_quot((term * x2) >> 30, dv);
            if (k[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            r = 16'd0;
        end else begin
            q = ($unsigned(sum) + 64'd16384) >> 15;
            r = (q > 64'd32767) ? 16'd32767 : q[15:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/spcs_ctrl.sv -----
// Controller state machine that sequences one tick through the datapath.
module spcs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  spcs_pkg::stat_t stat,
    output spcs_pkg::cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECODE = 9'b000000010,
        ST_DIV    = 9'b000000100,
        ST_FIX    = 9'b000001000,
        ST_EMUL   = 9'b000010000,
        ST_READ   = 9'b000100000,
        ST_MUL    = 9'b001000000,
        ST_STORE  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t           state_reg, state_next;
    spcs_pkg::phase_t phase_reg, phase_next;

    // State and phase counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= spcs_pkg::PH_U;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cmd          = '0;
        cmd.phase    = phase_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                phase_next = spcs_pkg::PH_U;
                if (stat.start_cmd) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.advance = 1'b1;
                    if (stat.closed) begin
                        cmd.div_load = 1'b1;
                        state_next   = ST_DIV;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.enc_fix = 1'b1;
                state_next  = ST_EMUL;
            end
            ST_EMUL: begin
                cmd.enc_mul = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ: begin
                cmd.rom_read = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                case (phase_reg)
                    spcs_pkg::PH_U: begin
                        phase_next = spcs_pkg::PH_V;
                        state_next = ST_READ;
                    end
                    spcs_pkg::PH_V: begin
                        phase_next = spcs_pkg::PH_W;
                        state_next = ST_READ;
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/spcs_datapath.sv -----
// Datapath: configuration, stage state, remainder unit, cosine ROM and compare values.
module spcs_datapath #(
    parameter int unsigned COS_TABLE_BITS         = spcs_pkg::COS_TABLE_BITS_DEF,
    parameter int unsigned ENCODER_COUNTS_PER_REV = spcs_pkg::ENCODER_COUNTS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_wdata,
    input  spcs_pkg::in_t   s_data,
    input  spcs_pkg::cmd_t  cmd,
    output spcs_pkg::stat_t stat,
    output logic            m_valid,
    input  logic            m_ready,
    output spcs_pkg::out_t  m_data
);

    localparam int unsigned TAB_N = 1 << COS_TABLE_BITS;
    localparam logic [15:0] CPE_RESET = 16'(ENCODER_COUNTS_PER_REV / 4);
    localparam logic [31:0] C2P_RESET = 32'(64'h1_0000_0000 / (ENCODER_COUNTS_PER_REV / 4));

    typedef logic [15:0] cos_rom_t [TAB_N];

    function automatic cos_rom_t build_rom();
        cos_rom_t t;
        for (int unsigned i = 0; i < TAB_N; i++) begin
            t[i] = spcs_pkg::cos_entry(i, COS_TABLE_BITS);
        end
        return t;
    endfunction

    localparam cos_rom_t COS_ROM = build_rom();

    // Configuration registers.
    logic [15:0] steps_reg;
    logic [6:0]  pole_reg;
    logic [31:0] phase_step_reg;
    logic [15:0] cpe_reg;
    logic [31:0] c2p_reg;
    logic [15:0] duty_max_reg;
    logic [15:0] reload_reg;
    logic        invert_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg      <= spcs_pkg::STEPS_RESET;
            pole_reg       <= spcs_pkg::POLE_RESET;
            phase_step_reg <= spcs_pkg::PHASE_STEP_RESET;
            cpe_reg        <= CPE_RESET;
            c2p_reg        <= C2P_RESET;
            duty_max_reg   <= spcs_pkg::DUTY_RESET;
            reload_reg     <= spcs_pkg::RELOAD_RESET;
            invert_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (spcs_pkg::cfg_index_t'(cfg_index))
                spcs_pkg::REG_STEPS_PER_TURN:  steps_reg      <= cfg_wdata[15:0];
                spcs_pkg::REG_POLE_RATIO:      pole_reg       <= cfg_wdata[6:0];
                spcs_pkg::REG_PHASE_STEP:      phase_step_reg <= cfg_wdata;
                spcs_pkg::REG_COUNTS_PER_TURN: cpe_reg        <= cfg_wdata[15:0];
                spcs_pkg::REG_COUNT_TO_PHASE:  c2p_reg        <= cfg_wdata;
                spcs_pkg::REG_DUTY_MAX:        duty_max_reg   <= cfg_wdata[15:0];
                spcs_pkg::REG_RELOAD_VALUE:    reload_reg     <= cfg_wdata[15:0];
                spcs_pkg::REG_INVERT_MODE:     invert_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Captured request.
    logic        start_reg;
    logic [31:0] pos_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            start_reg <= s_data.command;
            pos_reg   <= s_data.encoder_position;
        end
    end

    // Stage sequencing state.
    logic [31:0] tick_reg, tick_next;
    logic [1:0]  stage_reg, stage_next;
    logic [31:0] angle_reg, angle_next;
    logic [1:0]  ran_reg;
    logic [22:0] open_len;
    logic [15:0] remf_reg;

    assign open_len = {16'd0, pole_reg} * {7'd0, steps_reg};

    always_comb begin
        tick_next  = tick_reg;
        stage_next = stage_reg;
        angle_next = angle_reg;
        if (cmd.clear) begin
            tick_next  = 32'd0;
            stage_next = spcs_pkg::STG_ALIGN;
        end else if (cmd.advance) begin
            tick_next = tick_reg + 32'd1;
            if (stage_reg == spcs_pkg::STG_ALIGN) begin
                angle_next = 32'd0;
                if (tick_reg >= {16'd0, steps_reg}) begin
                    tick_next  = 32'd0;
                    stage_next = spcs_pkg::STG_OPEN;
                end
            end else if (stage_reg == spcs_pkg::STG_OPEN) begin
                angle_next = angle_reg + phase_step_reg;
                if (tick_reg >= {9'd0, open_len}) begin
                    stage_next = spcs_pkg::STG_CLOSED;
                end
            end
        end else if (cmd.enc_mul) begin
            angle_next = 32'(remf_reg * c2p_reg) + spcs_pkg::QUARTER_TURN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg  <= 32'd0;
            stage_reg <= spcs_pkg::STG_ALIGN;
            angle_reg <= 32'd0;
        end else begin
            tick_reg  <= tick_next;
            stage_reg <= stage_next;
            angle_reg <= angle_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.advance) begin
            ran_reg <= stage_reg;
        end
    end

    // Bit-serial remainder of the encoder count by the encoder modulus.
    logic [15:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [4:0]  div_cnt_reg;
    logic        neg_reg;
    logic [16:0] trial;

    assign trial = {rem_reg, dvd_reg[31]};

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            neg_reg     <= pos_reg[31];
            dvd_reg     <= pos_reg[31] ? (32'd0 - pos_reg) : pos_reg;
            rem_reg     <= 16'd0;
            div_cnt_reg <= 5'd0;
        end else if (cmd.div_step) begin
            rem_reg     <= (trial >= {1'b0, cpe_reg}) ? 16'(trial - {1'b0, cpe_reg})
                                                      : trial[15:0];
            dvd_reg     <= {dvd_reg[30:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 5'd1;
        end
    end

    // Floored remainder, zero for a zero modulus.
    always_ff @(posedge aclk) begin
        if (cmd.enc_fix) begin
            if (cpe_reg == 16'd0) begin
                remf_reg <= 16'd0;
            end else if (neg_reg && rem_reg != 16'd0) begin
                remf_reg <= cpe_reg - rem_reg;
            end else begin
                remf_reg <= rem_reg;
            end
        end
    end

    // Cosine lookup for the selected phase, one registered ROM read.
    logic [31:0]               ph_angle;
    logic [1:0]                quad;
    logic [COS_TABLE_BITS-1:0] idx;
    logic [COS_TABLE_BITS-1:0] rom_addr;
    logic [15:0]               rom_q_reg;
    logic                      cos_neg_reg;
    logic                      cos_zero_reg;

    assign ph_angle = angle_reg - spcs_pkg::phase_offset(cmd.phase);
    assign quad     = ph_angle[31:30];
    assign idx      = ph_angle[29 -: COS_TABLE_BITS];
    assign rom_addr = quad[0] ? (COS_TABLE_BITS'(0) - idx) : idx;

    always_ff @(posedge aclk) begin
        if (cmd.rom_read) begin
            rom_q_reg    <= COS_ROM[rom_addr];
            cos_neg_reg  <= (quad == 2'd1) || (quad == 2'd2);
            cos_zero_reg <= quad[0] && (idx == '0);
        end
    end

    // Scale by the peak compare value.
    logic [15:0] frac;
    logic [31:0] prod_reg;
    logic [15:0] level;
    logic [15:0] cmp_val;

    always_comb begin
        if (cos_zero_reg) begin
            frac = spcs_pkg::COS_OFFSET;
        end else if (cos_neg_reg) begin
            frac = spcs_pkg::COS_OFFSET - rom_q_reg;
        end else begin
            frac = spcs_pkg::COS_OFFSET + rom_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= duty_max_reg * frac;
        end
    end

    assign level   = prod_reg[31:16];
    assign cmp_val = invert_reg ? (reload_reg - level) : level;

    // Per-phase compare values.
    logic [15:0] duty_u_reg;
    logic [15:0] duty_v_reg;
    logic [15:0] duty_w_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            case (cmd.phase)
                spcs_pkg::PH_U: duty_u_reg <= cmp_val;
                spcs_pkg::PH_V: duty_v_reg <= cmp_val;
                spcs_pkg::PH_W: duty_w_reg <= cmp_val;
                default: ;
            endcase
        end
    end

    // Output register.
    logic           m_valid_reg;
    spcs_pkg::out_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.duty_u           <= duty_u_reg;
            out_reg.duty_v           <= duty_v_reg;
            out_reg.duty_w           <= duty_w_reg;
            out_reg.stage            <= ran_reg;
            out_reg.encoder_reset    <= (ran_reg == spcs_pkg::STG_ALIGN);
            out_reg.electrical_angle <= angle_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Status back to the controller.
    assign stat.start_cmd = start_reg;
    assign stat.closed    = (stage_reg == spcs_pkg::STG_CLOSED);
    assign stat.div_last  = (div_cnt_reg == 5'd31);
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule

// ----- rtl/sine_pwm_commutation_sequencer.sv -----
// Top level of the three-phase sine PWM commutation sequencer.
//
// Usage: each request on the s_ channel is either a start command, which clears
// the tick counter and returns to the align stage without a result, or a PWM
// update tick carrying the encoder count. Each tick yields one result on the
// m_ channel with the three compare values, the stage that ran, the encoder
// reset flag and the electrical angle. Registers are to be written through
// the cfg_ port only while the block is idle; the block does not enforce it.
// Sequence: a start command goes from accept through decode back to idle. A
// tick goes through decode and then, for each phase in turn, a ROM read, a
// multiply and a store; a closed-loop tick first runs the bit-serial remainder
// unit (one bit a cycle over 32 bits), the remainder fix and the encoder
// multiply. The three compare values share one ROM read and one multiplier.
// Reset: registers take their reset values, the stage returns to align and the
// angle to zero; the cosine ROM is constant and needs no fill.
// Stall: the result sits in an output register; the next request is still
// accepted and worked on, and only its final load waits until m_ready.
module sine_pwm_commutation_sequencer #(
    parameter int unsigned COS_TABLE_BITS         = spcs_pkg::COS_TABLE_BITS_DEF,
    parameter int unsigned ENCODER_COUNTS_PER_REV = spcs_pkg::ENCODER_COUNTS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  spcs_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output spcs_pkg::out_t m_data
);

    spcs_pkg::cmd_t  cmd;
    spcs_pkg::stat_t stat;

    // Sequencer.
    spcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic and state.
    spcs_datapath #(
        .COS_TABLE_BITS         (COS_TABLE_BITS),
        .ENCODER_COUNTS_PER_REV (ENCODER_COUNTS_PER_REV)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
